>>> design/pbf_pkg.sv
// shared types, constants and sizing for the partitioned bloom filter
package pbf_pkg;

    localparam int MAX_PARTITIONS  = 16;
    localparam int PARTITION_DEPTH = 65536;

    // field widths fixed by the interface
    localparam int NUMP_W  = 5;
    localparam int PBITS_W = 17;
    localparam int LIMIT_W = 21;
    localparam int NEW_W   = 5;
    localparam int HASH_W  = 64;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // store organization
    localparam int PART_W   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int PCNT_W   = PART_W + 1;
    localparam int IDX_W    = $clog2(PARTITION_DEPTH);
    localparam int SIZE_W   = IDX_W + 1;
    localparam int ROW_BITS = (PARTITION_DEPTH >= 128) ? 64 : PARTITION_DEPTH / 2;
    localparam int OFF_W    = $clog2(ROW_BITS);
    localparam int ROW_W    = PART_W + IDX_W - OFF_W;
    localparam int NUM_ROWS = MAX_PARTITIONS * (PARTITION_DEPTH / ROW_BITS);
    localparam int PROD_W   = WORD_W + SIZE_W;

    localparam logic [LIMIT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTITIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_LIMIT     = 2'd2;

    localparam logic [NUMP_W-1:0]  RESET_NUM_PARTITIONS = 5'd11;
    localparam logic [PBITS_W-1:0] RESET_PARTITION_BITS = 17'd65536;
    localparam logic [LIMIT_W-1:0] RESET_FILL_LIMIT     = 21'd360448;

    typedef enum logic
    {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // one classified item waiting for the back end
    typedef struct packed
    {
        op_t               op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } cmd_t;

    // effective configuration, already saturated
    typedef struct packed
    {
        logic [PCNT_W-1:0]  parts;
        logic [SIZE_W-1:0]  size;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    // one finished result
    typedef struct packed
    {
        logic             hit;
        logic [NEW_W-1:0] new_bits;
        logic             full_res;
    } res_t;

endpackage

>>> design/pbf_front.sv
// front end: takes items, splits the hash and holds them in a two-entry queue
module pbf_front
    import pbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              op,
    input  logic [HASH_W-1:0] hash_value,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output cmd_t              cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;
    cmd_t       cmd_in;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.op = op_t'(op);
        cmd_in.a  = hash_value[WORD_W-1:0];
        cmd_in.b  = hash_value[HASH_W-1:WORD_W];
    end

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> design/pbf_back.sv
// back end: probe sequencer, bit store with read-modify-write, count and result
module pbf_back
    import pbf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    output logic cmd_pop,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_pop,
    output res_t res
);

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [ROW_BITS-1:0] mem [NUM_ROWS];

    logic [ROW_W-1:0]    clr_row_reg;
    op_t                 op_reg;
    logic [WORD_W-1:0]   a_reg;
    logic [WORD_W-1:0]   b_reg;
    logic [PART_W-1:0]   part_reg;

    // stage 1: reduced index
    logic                p1_vld_reg;
    logic [PART_W-1:0]   p1_part_reg;
    logic [IDX_W-1:0]    p1_idx_reg;

    // stage 2: row read back
    logic                p2_vld_reg;
    logic [ROW_W-1:0]    p2_row_reg;
    logic [OFF_W-1:0]    p2_off_reg;
    logic [ROW_BITS-1:0] rd_data_reg;

    logic [PCNT_W-1:0]   fresh_reg;
    logic                all_set_reg;
    logic [LIMIT_W-1:0]  count_reg;

    logic                res_vld_reg;
    res_t                res_reg;

    logic [PROD_W-1:0]   prod;
    logic                last_probe;
    logic                was_set;
    logic [ROW_BITS-1:0] set_mask;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;
    logic [ROW_W-1:0]    mem_raddr;
    logic                slot_free;
    logic                pipe_empty;
    logic                res_load;

    assign prod       = PROD_W'(a_reg) * PROD_W'(cfg.size);
    assign last_probe = (PCNT_W'(part_reg) + PCNT_W'(1)) == cfg.parts;
    assign was_set    = rd_data_reg[p2_off_reg];
    assign set_mask   = ROW_BITS'(1) << p2_off_reg;
    assign slot_free  = !res_vld_reg || res_pop;
    assign pipe_empty = !p1_vld_reg && !p2_vld_reg;
    assign res_load   = (state_reg == ST_FINISH) && pipe_empty && slot_free;

    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    assign mem_raddr = {p1_part_reg, p1_idx_reg[IDX_W-1:OFF_W]};

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_row_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = p2_vld_reg && (op_reg == OP_ADD);
            mem_waddr = p2_row_reg;
            mem_wdata = rd_data_reg | set_mask;
        end
    end

    // bit store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p1_part_reg <= part_reg;
        p1_idx_reg  <= prod[WORD_W +: IDX_W];
        p2_row_reg  <= mem_raddr;
        p2_off_reg  <= p1_idx_reg[OFF_W-1:0];
        if (state_reg == ST_IDLE)
        begin
            op_reg <= cmd.op;
            a_reg  <= cmd.a;
            b_reg  <= cmd.b;
        end
        else if (state_reg == ST_PROBE)
        begin
            a_reg <= a_reg + b_reg;
            b_reg <= b_reg + WORD_W'(part_reg);
        end
        if (res_load)
        begin
            res_reg.hit      <= (op_reg == OP_ADD) ? (fresh_reg != '0) : all_set_reg;
            res_reg.new_bits <= NEW_W'(fresh_reg);
            res_reg.full_res <= (count_reg >= cfg.limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_row_reg <= '0;
            part_reg    <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            fresh_reg   <= '0;
            all_set_reg <= 1'b1;
            count_reg   <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= (state_reg == ST_PROBE);
            p2_vld_reg <= p1_vld_reg;

            if (res_load)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (res_pop && res_vld_reg)
            begin
                res_vld_reg <= 1'b0;
            end

            // retire one probe
            if (p2_vld_reg)
            begin
                if (op_reg == OP_ADD)
                begin
                    if (!was_set)
                    begin
                        fresh_reg <= fresh_reg + PCNT_W'(1);
                        if (count_reg != COUNT_MAX)
                        begin
                            count_reg <= count_reg + LIMIT_W'(1);
                        end
                    end
                end
                else if (!was_set)
                begin
                    all_set_reg <= 1'b0;
                end
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + ROW_W'(1);
                    if (clr_row_reg == ROW_W'(NUM_ROWS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        part_reg    <= '0;
                        fresh_reg   <= '0;
                        all_set_reg <= 1'b1;
                        state_reg   <= (cfg.parts == '0) ? ST_FINISH : ST_PROBE;
                    end
                end
                ST_PROBE:
                begin
                    part_reg <= part_reg + PART_W'(1);
                    if (last_probe)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (res_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/partitioned_bloom_filter_core.sv
// partitioned bloom filter: each item probes k = min(num_partitions, 16) partitions, one store
// row read-modify-write per partition, and k = 0 gives a result with no probe; the back end
// takes a new item only once the result of the last one is loaded
// a two-entry queue takes items while the back end works; the result register holds one result
// reset clears control state and the set-bit count, then a clearing pass over 16384 rows
// zeroes the bit store; no item is processed during the pass, configuration writes still land
module partitioned_bloom_filter_core
    import pbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  op,
    input  logic [HASH_W-1:0]     hash_value,
    output logic                  empty,
    input  logic                  pop,
    output logic                  hit,
    output logic [NEW_W-1:0]      new_bits,
    output logic                  full_res,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    logic [NUMP_W-1:0]  num_partitions_reg;
    logic [PBITS_W-1:0] partition_bits_reg;
    logic [LIMIT_W-1:0] fill_limit_reg;

    cfg_t cfg;
    cmd_t cmd;
    res_t res;
    logic cmd_valid;
    logic cmd_pop;
    logic res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_partitions_reg <= RESET_NUM_PARTITIONS;
            partition_bits_reg <= RESET_PARTITION_BITS;
            fill_limit_reg     <= RESET_FILL_LIMIT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_NUM_PARTITIONS: num_partitions_reg <= wr_data[NUMP_W-1:0];
                REG_PARTITION_BITS: partition_bits_reg <= wr_data[PBITS_W-1:0];
                REG_FILL_LIMIT:     fill_limit_reg     <= wr_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // saturate partition count and size to what the store holds
    always_comb
    begin
        cfg.parts = (32'(num_partitions_reg) > MAX_PARTITIONS)
                  ? PCNT_W'(MAX_PARTITIONS) : PCNT_W'(num_partitions_reg);
        cfg.size  = (32'(partition_bits_reg) > PARTITION_DEPTH)
                  ? SIZE_W'(PARTITION_DEPTH) : SIZE_W'(partition_bits_reg);
        cfg.limit = fill_limit_reg;
    end

    pbf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .hash_value (hash_value),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd)
    );

    pbf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_pop   (pop),
        .res       (res)
    );

    assign empty    = !res_valid;
    assign hit      = res.hit;
    assign new_bits = res.new_bits;
    assign full_res = res.full_res;

endmodule

>>> design/pbf_checker.sv
// port checker for the partitioned bloom filter and its bind
module pbf_checker
    import pbf_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic             hit,
    input logic [NEW_W-1:0] new_bits,
    input logic             full_res
);

    // an add that set bits always reports a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (new_bits != '0)) |-> hit)
    else $error("new bits reported without hit");

    // never more new bits than the maximum partition count
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(new_bits) <= MAX_PARTITIONS))
    else $error("new bits above partition count");

    // a waiting result holds until its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(hit) && $stable(new_bits)
                              && $stable(full_res)))
    else $error("waiting result changed");

endmodule

bind partitioned_bloom_filter_core pbf_checker u_pbf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .hit      (hit),
    .new_bits (new_bits),
    .full_res (full_res)
);

>>> tb/testbench.sv
// self-checking testbench for the partitioned bloom filter core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pbf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 98;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // expected filter contents, running count and the results still owed by the block
    class bloom_scoreboard;
        bit filter_bits [MAX_PARTITIONS][PARTITION_DEPTH];
        logic [LIMIT_W-1:0] set_count;
        logic [NUMP_W-1:0] num_parts;
        logic [PBITS_W-1:0] part_size;
        logic [LIMIT_W-1:0] fill_limit;
        res_t expected_results[$];
        int unsigned mismatch_count;

        function new();
            set_count = '0;
            num_parts = RESET_NUM_PARTITIONS;
            part_size = RESET_PARTITION_BITS;
            fill_limit = RESET_FILL_LIMIT;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NUM_PARTITIONS: num_parts = data[NUMP_W-1:0];
                REG_PARTITION_BITS: part_size = data[PBITS_W-1:0];
                REG_FILL_LIMIT: fill_limit = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // probe every partition by double hashing and predict the result
        function void record_item(op_t kind, logic [HASH_W-1:0] hash);
            logic [WORD_W-1:0] a;
            logic [WORD_W-1:0] b;
            logic [63:0] prod;
            logic [LIMIT_W:0] sum;
            int unsigned k;
            int unsigned size;
            int unsigned slot;
            int unsigned fresh;
            bit all_set;
            res_t r;
            a = hash[WORD_W-1:0];
            b = hash[HASH_W-1:WORD_W];
            k = (num_parts > MAX_PARTITIONS) ? MAX_PARTITIONS : num_parts;
            size = (part_size > PARTITION_DEPTH) ? PARTITION_DEPTH : part_size;
            fresh = 0;
            all_set = 1'b1;
            for (int i = 0; i < k; i++)
            begin
                prod = 64'(a) * 64'(size);
                slot = prod[63:32];
                if (kind == OP_ADD)
                begin
                    if (!filter_bits[i][slot])
                        fresh++;
                    filter_bits[i][slot] = 1'b1;
                end
                else if (!filter_bits[i][slot])
                    all_set = 1'b0;
                a = a + b;
                b = b + 32'(i);
            end
            if (kind == OP_ADD)
            begin
                sum = {1'b0, set_count} + (LIMIT_W+1)'(fresh);
                set_count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[LIMIT_W-1:0];
                r.hit = (fresh > 0);
                r.new_bits = NEW_W'(fresh);
            end
            else
            begin
                r.hit = all_set;
                r.new_bits = '0;
            end
            r.full_res = (set_count >= fill_limit);
            expected_results.push_back(r);
        endfunction

        function void compare_result(logic hit, logic [NEW_W-1:0] nb, logic fr);
            res_t want;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no transaction waiting: hit=%0b new_bits=%0d full_res=%0b",
                             $time, hit, nb, fr);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.hit !== hit || want.new_bits !== nb || want.full_res !== fr)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch: expected hit=%0b new_bits=%0d full_res=%0b, got hit=%0b new_bits=%0d full_res=%0b",
                                 $time, want.hit, want.new_bits, want.full_res, hit, nb, fr);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic op = 1'b0;
    logic [HASH_W-1:0] hash_value = '0;
    logic empty;
    logic pop = 1'b0;
    logic hit;
    logic [NEW_W-1:0] new_bits;
    logic full_res;
    logic wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    bloom_scoreboard sb;
    int send_idle_pct = 14;
    int recv_idle_pct = 14;
    int unsigned cycle_count = 0;

    partitioned_bloom_filter_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .op(op),
        .hash_value(hash_value),
        .empty(empty),
        .pop(pop),
        .hit(hit),
        .new_bits(new_bits),
        .full_res(full_res),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("partitioned_bloom_filter_core regression: fail");
        $finish;
    end

    // result side: random pop stalls, check at the rising edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.compare_result(hit, new_bits, full_res);
            @(negedge clk);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // push stays high after a transaction unless the next call idles
    task automatic send_item(input op_t kind, input logic [HASH_W-1:0] hash);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        op <= kind;
        hash_value <= hash;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.record_item(kind, hash);
        @(negedge clk);
    endtask

    // hold off until every owed result is out, then let the pipeline empty
    task automatic settle_block();
        push <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (2 * MAX_PARTITIONS) @(negedge clk);
    endtask

    initial
    begin
        logic [HASH_W-1:0] hash_pool[$];
        logic [HASH_W-1:0] h;
        logic [CFG_DATA_W-1:0] data;
        op_t kind;
        int r;
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full width, zero fill limit: full flag always set
        write_reg(REG_NUM_PARTITIONS, CFG_DATA_W'(16));
        write_reg(REG_PARTITION_BITS, CFG_DATA_W'(65536));
        write_reg(REG_FILL_LIMIT, '0);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        send_item(OP_QUERY, '0);
        send_item(OP_ADD, '0);
        send_item(OP_ADD, '0);
        send_item(OP_QUERY, '0);
        send_item(OP_ADD, '1);
        send_item(OP_QUERY, '1);
        send_item(OP_QUERY, 64'h8000_0000_0000_0000);
        send_item(OP_ADD, 64'h0000_0001_ffff_ffff);
        send_item(OP_QUERY, 64'hffff_ffff_0000_0000);

        // no partitions, oversized partition, top fill limit
        settle_block();
        write_reg(REG_NUM_PARTITIONS, '0);
        write_reg(REG_PARTITION_BITS, CFG_DATA_W'(131071));
        write_reg(REG_FILL_LIMIT, CFG_DATA_W'(COUNT_MAX));
        send_item(OP_ADD, {$urandom, $urandom});
        send_item(OP_QUERY, {$urandom, $urandom});
        send_item(OP_ADD, '1);

        // too many partitions, zero partition size
        settle_block();
        write_reg(REG_NUM_PARTITIONS, CFG_DATA_W'(31));
        write_reg(REG_PARTITION_BITS, '0);
        write_reg(REG_FILL_LIMIT, CFG_DATA_W'(sb.set_count) + 1'b1);
        send_item(OP_ADD, {$urandom, $urandom});
        send_item(OP_QUERY, {$urandom, $urandom});
        send_item(OP_ADD, {$urandom, $urandom});

        // one partition of two bits; the full flag rises on the add
        settle_block();
        write_reg(REG_NUM_PARTITIONS, CFG_DATA_W'(1));
        write_reg(REG_PARTITION_BITS, CFG_DATA_W'(2));
        write_reg(REG_FILL_LIMIT, CFG_DATA_W'(sb.set_count) + 1'b1);
        send_item(OP_QUERY, 64'h0000_0000_8000_0000);
        send_item(OP_ADD, 64'h0000_0000_8000_0000);
        send_item(OP_QUERY, 64'h0000_0000_8000_0000);
        send_item(OP_ADD, 64'h0000_0000_8000_0000);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle_block();
            case ($urandom_range(5))
                0: data = '0;
                1: data = CFG_DATA_W'(1);
                2: data = CFG_DATA_W'(16);
                3: data = CFG_DATA_W'(31);
                default: data = CFG_DATA_W'($urandom_range(31));
            endcase
            if (ph == 0)
                data = CFG_DATA_W'(16);
            write_reg(REG_NUM_PARTITIONS, data);
            case ($urandom_range(6))
                0: data = '0;
                1: data = CFG_DATA_W'(1);
                2: data = CFG_DATA_W'($urandom_range(64, 2));
                3: data = CFG_DATA_W'(65536);
                4: data = CFG_DATA_W'(131071);
                5: data = CFG_DATA_W'($urandom_range(131071));
                default: data = CFG_DATA_W'($urandom_range(4096, 65));
            endcase
            write_reg(REG_PARTITION_BITS, data);
            case ($urandom_range(5))
                0: data = '0;
                1: data = CFG_DATA_W'(sb.set_count) + CFG_DATA_W'($urandom_range(60));
                2: data = CFG_DATA_W'($urandom);
                3: data = '1;
                default: data = CFG_DATA_W'(sb.set_count) + CFG_DATA_W'($urandom_range(400));
            endcase
            write_reg(REG_FILL_LIMIT, data);
            if ($urandom_range(1) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

            // one phase runs with no idling on either side
            send_idle_pct = (ph == 3) ? 0 : 14;
            recv_idle_pct = (ph == 3) ? 0 : 14;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = ($urandom_range(99) < 50) ? OP_ADD : OP_QUERY;
                r = $urandom_range(99);
                // queries mostly reuse added hashes so that hits are common
                if (r < 2)
                    h = '0;
                else if (r < 5)
                    h = '1;
                else if (hash_pool.size() > 0 && r < ((kind == OP_ADD) ? 30 : 65))
                    h = hash_pool[$urandom_range(hash_pool.size() - 1)];
                else
                    h = {$urandom, $urandom};
                if (kind == OP_ADD)
                begin
                    hash_pool.push_back(h);
                    if (hash_pool.size() > 64)
                        void'(hash_pool.pop_front());
                end
                send_item(kind, h);
            end
        end

        settle_block();
        if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
            $display("partitioned_bloom_filter_core regression: pass");
        else
            $display("partitioned_bloom_filter_core regression: fail");
        $finish;
    end

endmodule
